// ----- src/dts_pkg.sv -----
// shared types, codes and keyword tables for the datalog token scanner
// used by dts_front, dts_queue, dts_back and datalog_token_scanner
package dts_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    // token kind codes
    localparam logic [4:0] KIND_COMMA     = 5'd0;
    localparam logic [4:0] KIND_PERIOD    = 5'd1;
    localparam logic [4:0] KIND_QMARK     = 5'd2;
    localparam logic [4:0] KIND_LPAREN    = 5'd3;
    localparam logic [4:0] KIND_RPAREN    = 5'd4;
    localparam logic [4:0] KIND_COLON     = 5'd5;
    localparam logic [4:0] KIND_COLONDASH = 5'd6;
    localparam logic [4:0] KIND_MUL       = 5'd7;
    localparam logic [4:0] KIND_ADD       = 5'd8;
    localparam logic [4:0] KIND_SCHEMES   = 5'd9;
    localparam logic [4:0] KIND_FACTS     = 5'd10;
    localparam logic [4:0] KIND_RULES     = 5'd11;
    localparam logic [4:0] KIND_QUERIES   = 5'd12;
    localparam logic [4:0] KIND_ID        = 5'd13;
    localparam logic [4:0] KIND_STRING    = 5'd14;
    localparam logic [4:0] KIND_COMMENT   = 5'd15;
    localparam logic [4:0] KIND_UNDEF     = 5'd16;
    localparam logic [4:0] KIND_EOF       = 5'd17;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_QUOTE   = 8'h27;

    // keyword text, zero padded: Schemes, Facts, Rules, Queries
    localparam logic [7:0] KW_TEXT [4][8] = '{
        '{8'h53, 8'h63, 8'h68, 8'h65, 8'h6D, 8'h65, 8'h73, 8'h00},
        '{8'h46, 8'h61, 8'h63, 8'h74, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h75, 8'h6C, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h51, 8'h75, 8'h65, 8'h72, 8'h69, 8'h65, 8'h73, 8'h00}
    };
    localparam logic [2:0] KW_LEN [4]  = '{3'd7, 3'd5, 3'd5, 3'd7};
    localparam logic [4:0] KW_KIND [4] = '{KIND_SCHEMES, KIND_FACTS, KIND_RULES, KIND_QUERIES};

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COLON,
        MODE_IDENT,
        MODE_HASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STRING
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_line;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } token_t;

    // one queue entry: the tokens caused by one input transaction
    typedef struct packed {
        token_t tok_a;
        token_t tok_b;
    } scan_entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ----- src/dts_front.sv -----
// front end: accepts bytes, runs the scan mode machine and counters
// builds one queue entry of up to two tokens per transaction; uses dts_pkg
module dts_front #(
    parameter int LENGTH_BITS = dts_pkg::LENGTH_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  dts_pkg::src_item_t   src_data,
    input  logic                 q_full,
    output logic                 q_push,
    output dts_pkg::scan_entry_t q_entry
);

    localparam int LEN_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [31:0] off;
        logic [15:0] len;
    } token_fields_b_t;

    dts_pkg::scan_mode_t mode_reg, mode_next;
    logic [15:0]      line_count_reg, line_count_next;
    logic [31:0]      byte_offset_reg, byte_offset_next;
    logic [15:0]      tok_line_reg, tok_line_next;
    logic [31:0]      tok_off_reg, tok_off_next;
    logic [LEN_W-1:0] tok_len_reg, tok_len_next;
    logic [3:0]       kw_match_reg, kw_match_next;
    logic             saw_reg, saw_next;
    logic             line_open_reg, line_open_next;

    logic             accept;
    logic [7:0]       c;
    logic [LEN_W-1:0] len_grown;
    logic [3:0]       kw_keep;
    logic [3:0]       kw_first;
    logic [4:0]       id_kind;
    logic             emit_a, emit_b, rescan;
    logic [4:0]       kind_a;
    logic [LEN_W-1:0] len_a;

    token_fields_b_t tok_b;

    assign accept    = src_valid && !q_full;
    assign src_stall = q_full;
    assign c         = src_data.char_code;
    assign len_grown = (tok_len_reg == LEN_MAX) ? tok_len_reg : tok_len_reg + 1'b1;

    // keyword match against the byte at the current token position
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            kw_keep[k]  = (tok_len_reg < LEN_W'(8)) &&
                          (dts_pkg::KW_TEXT[k][tok_len_reg[2:0]] == c);
            kw_first[k] = (dts_pkg::KW_TEXT[k][0] == c);
        end
    end

    // identifier kind from surviving keyword candidates
    always_comb
    begin
        id_kind = dts_pkg::KIND_ID;
        for (int k = 3; k >= 0; k--)
        begin
            if (kw_match_reg[k] && tok_len_reg == LEN_W'(dts_pkg::KW_LEN[k]))
            begin
                id_kind = dts_pkg::KW_KIND[k];
            end
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= dts_pkg::MODE_IDLE;
            line_count_reg  <= 16'd1;
            byte_offset_reg <= '0;
            tok_line_reg    <= '0;
            tok_off_reg     <= '0;
            tok_len_reg     <= '0;
            kw_match_reg    <= 4'hF;
            saw_reg         <= 1'b0;
            line_open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            line_count_reg  <= line_count_next;
            byte_offset_reg <= byte_offset_next;
            tok_line_reg    <= tok_line_next;
            tok_off_reg     <= tok_off_next;
            tok_len_reg     <= tok_len_next;
            kw_match_reg    <= kw_match_next;
            saw_reg         <= saw_next;
            line_open_reg   <= line_open_next;
        end
    end

    // next state and emitted tokens
    always_comb
    begin
        mode_next        = mode_reg;
        line_count_next  = line_count_reg;
        byte_offset_next = byte_offset_reg;
        tok_line_next    = tok_line_reg;
        tok_off_next     = tok_off_reg;
        tok_len_next     = tok_len_reg;
        kw_match_next    = kw_match_reg;
        saw_next         = saw_reg;
        line_open_next   = line_open_reg;
        emit_a           = 1'b0;
        kind_a           = dts_pkg::KIND_UNDEF;
        len_a            = tok_len_reg;
        emit_b           = 1'b0;
        rescan           = 1'b0;
        tok_b.kind       = dts_pkg::KIND_UNDEF;
        tok_b.line       = line_count_reg;
        tok_b.off        = byte_offset_reg;
        tok_b.len        = 16'd1;

        if (src_data.end_of_input)
        begin
            // flush pending token
            unique case (mode_reg) inside
                dts_pkg::MODE_COLON:
                begin
                    emit_a = 1'b1;
                    kind_a = dts_pkg::KIND_COLON;
                end
                dts_pkg::MODE_IDENT:
                begin
                    emit_a = 1'b1;
                    kind_a = id_kind;
                end
                dts_pkg::MODE_HASH, dts_pkg::MODE_LINE:
                begin
                    emit_a = 1'b1;
                    kind_a = dts_pkg::KIND_COMMENT;
                end
                dts_pkg::MODE_BLOCK:
                begin
                    emit_a = 1'b1;
                    kind_a = dts_pkg::KIND_UNDEF;
                end
                dts_pkg::MODE_STRING:
                begin
                    emit_a = 1'b1;
                    kind_a = saw_reg ? dts_pkg::KIND_STRING : dts_pkg::KIND_UNDEF;
                end
                default:
                begin
                end
            endcase
            // end-of-file token
            emit_b     = 1'b1;
            tok_b.kind = dts_pkg::KIND_EOF;
            tok_b.line = (line_open_reg && line_count_reg != 16'hFFFF) ?
                         line_count_reg + 16'd1 : line_count_reg;
            tok_b.len  = 16'd0;
            // back to reset state
            mode_next        = dts_pkg::MODE_IDLE;
            line_count_next  = 16'd1;
            byte_offset_next = '0;
            tok_line_next    = '0;
            tok_off_next     = '0;
            tok_len_next     = '0;
            kw_match_next    = 4'hF;
            saw_next         = 1'b0;
            line_open_next   = 1'b0;
        end
        else
        begin
            // continue the pending token
            unique case (mode_reg) inside
                dts_pkg::MODE_COLON:
                begin
                    emit_a = 1'b1;
                    if (c == dts_pkg::CH_DASH)
                    begin
                        kind_a    = dts_pkg::KIND_COLONDASH;
                        len_a     = len_grown;
                        mode_next = dts_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        kind_a = dts_pkg::KIND_COLON;
                        rescan = 1'b1;
                    end
                end
                dts_pkg::MODE_IDENT:
                begin
                    if (dts_pkg::is_alpha(c) || dts_pkg::is_digit(c))
                    begin
                        kw_match_next = kw_match_reg & kw_keep;
                        tok_len_next  = len_grown;
                    end
                    else
                    begin
                        emit_a = 1'b1;
                        kind_a = id_kind;
                        rescan = 1'b1;
                    end
                end
                dts_pkg::MODE_HASH:
                begin
                    if (c == dts_pkg::CH_BAR)
                    begin
                        tok_len_next = len_grown;
                        mode_next    = dts_pkg::MODE_BLOCK;
                        saw_next     = 1'b0;
                    end
                    else if (c == dts_pkg::CH_NEWLINE)
                    begin
                        emit_a = 1'b1;
                        kind_a = dts_pkg::KIND_COMMENT;
                        rescan = 1'b1;
                    end
                    else
                    begin
                        tok_len_next = len_grown;
                        mode_next    = dts_pkg::MODE_LINE;
                    end
                end
                dts_pkg::MODE_LINE:
                begin
                    if (c == dts_pkg::CH_NEWLINE)
                    begin
                        emit_a = 1'b1;
                        kind_a = dts_pkg::KIND_COMMENT;
                        rescan = 1'b1;
                    end
                    else
                    begin
                        tok_len_next = len_grown;
                    end
                end
                dts_pkg::MODE_BLOCK:
                begin
                    tok_len_next = len_grown;
                    if (saw_reg && c == dts_pkg::CH_HASH)
                    begin
                        emit_a    = 1'b1;
                        kind_a    = dts_pkg::KIND_COMMENT;
                        len_a     = len_grown;
                        mode_next = dts_pkg::MODE_IDLE;
                        saw_next  = 1'b0;
                    end
                    else
                    begin
                        saw_next = (c == dts_pkg::CH_BAR);
                    end
                end
                dts_pkg::MODE_STRING:
                begin
                    if (saw_reg)
                    begin
                        saw_next = 1'b0;
                        if (c == dts_pkg::CH_QUOTE)
                        begin
                            tok_len_next = len_grown;
                        end
                        else
                        begin
                            emit_a = 1'b1;
                            kind_a = dts_pkg::KIND_STRING;
                            rescan = 1'b1;
                        end
                    end
                    else
                    begin
                        tok_len_next = len_grown;
                        if (c == dts_pkg::CH_QUOTE)
                        begin
                            saw_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            // scan the byte as the start of a new token
            if (rescan)
            begin
                mode_next = dts_pkg::MODE_IDLE;
                if (!dts_pkg::is_space(c))
                begin
                    unique case (c) inside
                        dts_pkg::CH_COMMA:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_COMMA;
                        end
                        dts_pkg::CH_PERIOD:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_PERIOD;
                        end
                        dts_pkg::CH_QMARK:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_QMARK;
                        end
                        dts_pkg::CH_LPAREN:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_LPAREN;
                        end
                        dts_pkg::CH_RPAREN:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_RPAREN;
                        end
                        dts_pkg::CH_STAR:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_MUL;
                        end
                        dts_pkg::CH_PLUS:
                        begin
                            emit_b     = 1'b1;
                            tok_b.kind = dts_pkg::KIND_ADD;
                        end
                        dts_pkg::CH_COLON, dts_pkg::CH_HASH, dts_pkg::CH_QUOTE:
                        begin
                            mode_next     = (c == dts_pkg::CH_COLON) ? dts_pkg::MODE_COLON :
                                            (c == dts_pkg::CH_HASH)  ? dts_pkg::MODE_HASH :
                                                                       dts_pkg::MODE_STRING;
                            tok_line_next = line_count_reg;
                            tok_off_next  = byte_offset_reg;
                            tok_len_next  = LEN_W'(1);
                            saw_next      = 1'b0;
                        end
                        default:
                        begin
                            if (dts_pkg::is_alpha(c))
                            begin
                                mode_next     = dts_pkg::MODE_IDENT;
                                tok_line_next = line_count_reg;
                                tok_off_next  = byte_offset_reg;
                                tok_len_next  = LEN_W'(1);
                                saw_next      = 1'b0;
                                kw_match_next = kw_first;
                            end
                            else
                            begin
                                emit_b     = 1'b1;
                                tok_b.kind = dts_pkg::KIND_UNDEF;
                            end
                        end
                    endcase
                end
            end

            // line and offset counters
            if (c == dts_pkg::CH_NEWLINE)
            begin
                if (line_count_reg != 16'hFFFF)
                begin
                    line_count_next = line_count_reg + 16'd1;
                end
                line_open_next = 1'b0;
            end
            else
            begin
                line_open_next = 1'b1;
            end
            byte_offset_next = byte_offset_reg + 32'd1;
        end
    end

    // queue entry assembly
    always_comb
    begin
        q_push                     = accept && (emit_a || emit_b);
        q_entry.tok_b.token_kind   = tok_b.kind;
        q_entry.tok_b.start_line   = tok_b.line;
        q_entry.tok_b.start_offset = tok_b.off;
        q_entry.tok_b.token_length = tok_b.len;
        q_entry.tok_b.last_of_run  = 1'b1;
        if (emit_a)
        begin
            q_entry.tok_a.token_kind   = kind_a;
            q_entry.tok_a.start_line   = tok_line_reg;
            q_entry.tok_a.start_offset = tok_off_reg;
            q_entry.tok_a.token_length = 16'(len_a);
            q_entry.tok_a.last_of_run  = !emit_b;
        end
        else
        begin
            q_entry.tok_a = q_entry.tok_b;
        end
    end

    // reset state is restored right after an end-of-input transaction
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_data.end_of_input |=>
            line_count_reg == 16'd1 && byte_offset_reg == 32'd0 &&
            mode_reg == dts_pkg::MODE_IDLE)
        else $error("scanner state not restored after end of input");

    // a pending token always covers at least one byte
    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != dts_pkg::MODE_IDLE |-> tok_len_reg != '0)
        else $error("pending token with zero length");

endmodule

// ----- src/dts_queue.sv -----
// short queue of scan entries between front and back end
// register array with head read; uses dts_pkg
module dts_queue #(
    parameter int DEPTH = dts_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dts_pkg::scan_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output dts_pkg::scan_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dts_pkg::scan_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

endmodule

// ----- src/dts_back.sv -----
// back end: serializes queue entries into single token transactions
// holds the output register; uses dts_pkg
module dts_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  dts_pkg::scan_entry_t head_entry,
    output logic                 pop,
    output logic                 tok_valid,
    input  logic                 tok_stall,
    output dts_pkg::token_t      tok_data
);

    logic            idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    dts_pkg::token_t out_reg;
    dts_pkg::token_t cur;
    logic            load;

    // pick first or second token of the head entry
    assign cur  = idx_reg ? head_entry.tok_b : head_entry.tok_a;
    assign load = head_valid && (!out_valid_reg || !tok_stall);
    assign pop  = load && cur.last_of_run;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && tok_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = !cur.last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= cur;
        end
    end

    assign tok_valid = out_valid_reg;
    assign tok_data  = out_reg;

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == dts_pkg::KIND_EOF |-> tok_data.last_of_run)
        else $error("end-of-file token not marked last");

endmodule

// ----- src/datalog_token_scanner.sv -----
// datalog token scanner: one source byte per cycle in, token descriptors out
// first token of a byte goes through the queue entry and then the output register
// a byte is taken every cycle unless the queue is full; a byte with two tokens
// yields two transactions, absorbed by a four-entry queue before the output
// reset (async, active low) clears the control state at once; no clearing pass
// depends on dts_pkg, dts_front, dts_queue, dts_back
module datalog_token_scanner #(
    parameter int LENGTH_BITS = dts_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  dts_pkg::src_item_t src_data,
    output logic               tok_valid,
    input  logic               tok_stall,
    output dts_pkg::token_t    tok_data
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    dts_pkg::scan_entry_t q_in;
    dts_pkg::scan_entry_t q_head;

    // scan machine
    dts_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // decoupling queue
    dts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    // token output
    dts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_data   (tok_data)
    );

endmodule
